>>> design/madt_entry_stream_parser_macros.svh
// Assertion macros shared by the parser modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef MADT_ENTRY_STREAM_PARSER_MACROS_SVH
`define MADT_ENTRY_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MADT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("madt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MADT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("madt assertion failed");

`endif

>>> design/madt_pkg.sv
package madt_pkg;

  // Table limits on stored records.
  localparam int MAX_IO_CONTROLLERS = 8;
  localparam int MAX_OVERRIDES      = 16;

  localparam int IO_CNT_W  = $clog2(MAX_IO_CONTROLLERS + 1);
  localparam int OV_CNT_W  = $clog2(MAX_OVERRIDES + 1);
  localparam int CPU_CNT_W = 10;
  localparam logic [CPU_CNT_W-1:0] CPU_LIMIT = 10'd1023;

  // Table layout.
  localparam logic [31:0] WALK_FIRST  = 32'd44;
  localparam logic [29:0] LENGTH_WORD = 30'd1;   // bytes 4..7
  localparam logic [29:0] LAPIC_WORD  = 30'd9;   // bytes 36..39
  localparam int          REC_BYTES   = 10;      // record bytes 2..11

  // Record type codes.
  localparam logic [7:0] REC_LOCAL    = 8'd0;
  localparam logic [7:0] REC_IO       = 8'd1;
  localparam logic [7:0] REC_OVERRIDE = 8'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_IO       = 2'd0;
  localparam logic [1:0] KIND_OVERRIDE = 2'd1;
  localparam logic [1:0] KIND_SUMMARY  = 2'd2;

  // Result queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  record_index;
    logic [7:0]  id_or_source;
    logic [31:0] word_a;
    logic [31:0] gsi_base;
    logic        polarity_low;
    logic        trigger_level;
    logic [9:0]  lapic_count;
    logic [3:0]  io_count;
    logic [4:0]  ovr_count;
    logic        checksum_good;
    logic        table_usable;
  } out_item_t;

  // Queue writes requested by the walker for one byte.
  typedef struct packed {
    logic first;
    logic second;
  } madt_push_t;

endpackage

>>> design/madt_walker.sv
`include "madt_entry_stream_parser_macros.svh"

module madt_walker
  import madt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  in_item_t   item,
  output madt_push_t push,
  output out_item_t  first_item,
  output out_item_t  second_item
);

  logic [31:0]          byte_position, byte_position_next;
  logic [31:0]          declared_length, declared_length_next;
  logic [31:0]          local_address, local_address_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [31:0]          record_start, record_start_next;
  logic [7:0]           record_type, record_type_next;
  logic [7:0]           record_length, record_length_next;
  logic [7:0]           record_bytes [REC_BYTES];
  logic [7:0]           record_bytes_next [REC_BYTES];
  logic [CPU_CNT_W-1:0] cpus_seen, cpus_seen_next;
  logic [IO_CNT_W-1:0]  io_seen, io_seen_next;
  logic [OV_CNT_W-1:0]  overrides_seen, overrides_seen_next;
  logic                 walk_halted, walk_halted_next;

  logic [7:0]  b;
  logic        walking;
  logic [31:0] offset;
  logic [7:0]  bytes_view [REC_BYTES];
  logic        over_at_start;
  logic        over_after_one;
  logic        over_length;
  logic        finish;
  logic        begin_rec;
  logic        io_take;
  logic        ov_take;
  logic        cpu_take;
  out_item_t   rec_item;
  out_item_t   sum_item;

  always_comb begin
    b = item.data_byte;

    byte_position_next   = byte_position + 32'd1;
    declared_length_next = declared_length;
    local_address_next   = local_address;
    running_sum_next     = running_sum + b;
    record_start_next    = record_start;
    record_type_next     = record_type;
    record_length_next   = record_length;
    walk_halted_next     = walk_halted;

    if (byte_position[31:2] == LENGTH_WORD) begin
      declared_length_next[{byte_position[1:0], 3'b000} +: 8] =
        declared_length[{byte_position[1:0], 3'b000} +: 8] | b;
    end
    if (byte_position[31:2] == LAPIC_WORD) begin
      local_address_next[{byte_position[1:0], 3'b000} +: 8] =
        local_address[{byte_position[1:0], 3'b000} +: 8] | b;
    end

    walking = !walk_halted && (byte_position >= record_start);
    offset  = byte_position - record_start;

    // Record bytes as they stand once this byte is stored.
    for (int i = 0; i < REC_BYTES; i++) begin
      bytes_view[i] = (walking && offset == 32'(i + 2)) ? b : record_bytes[i];
    end

    over_at_start  = ({1'b0, record_start} + 33'd2) > {1'b0, declared_length};
    over_after_one = ({1'b0, record_start} + 33'd3) > {1'b0, declared_length};
    over_length    = ({1'b0, record_start} + {25'd0, b}) > {1'b0, declared_length};

    finish    = 1'b0;
    begin_rec = 1'b0;
    if (walking) begin
      priority if (offset == 32'd0) begin
        if (over_at_start) begin
          walk_halted_next = 1'b1;
        end else begin
          begin_rec = 1'b1;
        end
      end else if (offset == 32'd1) begin
        if (b == 8'd0 || over_length) begin
          walk_halted_next = 1'b1;
        end else begin
          record_length_next = b;
          if (b == 8'd1) begin
            // A one-byte record ends here and this byte opens the next one.
            finish            = 1'b1;
            record_start_next = record_start + 32'd1;
            if (over_after_one) begin
              walk_halted_next = 1'b1;
            end else begin
              begin_rec = 1'b1;
            end
          end else if (b == 8'd2) begin
            finish            = 1'b1;
            record_start_next = record_start + 32'd2;
          end
        end
      end else if (offset == 32'(record_length) - 32'd1) begin
        finish            = 1'b1;
        record_start_next = record_start + 32'(record_length);
      end else begin
        // A byte in the middle of a record is only stored.
      end
    end

    if (begin_rec) begin
      record_type_next   = b;
      record_length_next = 8'd0;
    end
    for (int i = 0; i < REC_BYTES; i++) begin
      record_bytes_next[i] = begin_rec ? 8'd0 : bytes_view[i];
    end

    io_take  = finish && record_type == REC_IO &&
               io_seen < IO_CNT_W'(MAX_IO_CONTROLLERS);
    ov_take  = finish && record_type == REC_OVERRIDE &&
               overrides_seen < OV_CNT_W'(MAX_OVERRIDES);
    cpu_take = finish && record_type == REC_LOCAL && cpus_seen < CPU_LIMIT;

    io_seen_next        = io_take  ? io_seen + IO_CNT_W'(1) : io_seen;
    overrides_seen_next = ov_take  ? overrides_seen + OV_CNT_W'(1) : overrides_seen;
    cpus_seen_next      = cpu_take ? cpus_seen + CPU_CNT_W'(1) : cpus_seen;

    rec_item = '0;
    if (io_take) begin
      rec_item.result_kind  = KIND_IO;
      rec_item.record_index = 4'(io_seen);
      rec_item.id_or_source = bytes_view[0];
      rec_item.word_a       = {bytes_view[5], bytes_view[4], bytes_view[3], bytes_view[2]};
      rec_item.gsi_base     = {bytes_view[9], bytes_view[8], bytes_view[7], bytes_view[6]};
    end else begin
      rec_item.result_kind   = KIND_OVERRIDE;
      rec_item.record_index  = 4'(overrides_seen);
      rec_item.id_or_source  = bytes_view[1];
      rec_item.word_a        = {bytes_view[5], bytes_view[4], bytes_view[3], bytes_view[2]};
      rec_item.polarity_low  = (bytes_view[6][1:0] == 2'b11);
      rec_item.trigger_level = (bytes_view[6][3:2] == 2'b11);
    end

    sum_item               = '0;
    sum_item.result_kind   = KIND_SUMMARY;
    sum_item.word_a        = local_address_next;
    sum_item.lapic_count   = cpus_seen_next;
    sum_item.io_count      = 4'(io_seen_next);
    sum_item.ovr_count     = 5'(overrides_seen_next);
    sum_item.checksum_good = (running_sum_next == 8'd0);
    sum_item.table_usable  = (local_address_next != 32'd0) && (io_seen_next != '0);

    push.first  = advance && (io_take || ov_take || item.last_byte);
    push.second = advance && (io_take || ov_take) && item.last_byte;
    first_item  = (io_take || ov_take) ? rec_item : sum_item;
    second_item = sum_item;

    // The summary closes the table; the next byte is offset zero again.
    if (item.last_byte) begin
      byte_position_next   = 32'd0;
      declared_length_next = 32'd0;
      local_address_next   = 32'd0;
      running_sum_next     = 8'd0;
      record_start_next    = WALK_FIRST;
      record_type_next     = REC_LOCAL;
      record_length_next   = 8'd0;
      cpus_seen_next       = '0;
      io_seen_next         = '0;
      overrides_seen_next  = '0;
      walk_halted_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 32'd0;
      declared_length <= 32'd0;
      local_address   <= 32'd0;
      running_sum     <= 8'd0;
      record_start    <= WALK_FIRST;
      record_type     <= REC_LOCAL;
      record_length   <= 8'd0;
      cpus_seen       <= '0;
      io_seen         <= '0;
      overrides_seen  <= '0;
      walk_halted     <= 1'b0;
    end else if (advance) begin
      byte_position   <= byte_position_next;
      declared_length <= declared_length_next;
      local_address   <= local_address_next;
      running_sum     <= running_sum_next;
      record_start    <= record_start_next;
      record_type     <= record_type_next;
      record_length   <= record_length_next;
      cpus_seen       <= cpus_seen_next;
      io_seen         <= io_seen_next;
      overrides_seen  <= overrides_seen_next;
      walk_halted     <= walk_halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < REC_BYTES; i++) begin
        record_bytes[i] <= record_bytes_next[i];
      end
    end
  end

  `MADT_ASSERT_NOW(second_needs_last, push.second, item.last_byte && push.first)
  `MADT_ASSERT_NEXT(halt_sticks, walk_halted && !(advance && item.last_byte), walk_halted)
  `MADT_ASSERT_NEXT(table_restart, advance && item.last_byte,
                    byte_position == 32'd0 && record_start == WALK_FIRST && io_seen == '0)

endmodule

>>> design/madt_result_fifo.sv
`include "madt_entry_stream_parser_macros.svh"

module madt_result_fifo
  import madt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  madt_push_t push,
  input  out_item_t  first_item,
  input  out_item_t  second_item,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  out_item_t               entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [FIFO_PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [FIFO_CNT_W-1:0]   count, count_next;
  logic                    pop;
  logic [FIFO_CNT_W-1:0]   n_push;

  always_comb begin
    // Room for a record and a summary, judged on the registered count only.
    room      = count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    out_valid = count != '0;
    out_item  = entries[rd_ptr];
    pop       = out_valid && out_ready;
    n_push    = FIFO_CNT_W'(push.first) + FIFO_CNT_W'(push.second);

    wr_ptr_next = wr_ptr + FIFO_PTR_W'(n_push);
    rd_ptr_next = pop ? rd_ptr + FIFO_PTR_W'(1) : rd_ptr;
    count_next  = count + n_push - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= first_item;
    end
    if (push.second) begin
      entries[wr_ptr + FIFO_PTR_W'(1)] <= second_item;
    end
  end

  `MADT_ASSERT_NOW(no_overflow, 1'b1, count <= FIFO_CNT_W'(FIFO_DEPTH))
  `MADT_ASSERT_NOW(push_with_room, push.first, room)
  `MADT_ASSERT_NEXT(pop_drains, pop && !push.first,
                    count == FIFO_CNT_W'($past(count) - FIFO_CNT_W'(1)))

endmodule

>>> design/madt_entry_stream_parser.sv
// Streaming parser for the multiple-interrupt-controller table. Feed the
// table one byte per transaction from offset zero and flag the final byte
// with last_byte. Each byte is held in an input register and parsed in a
// single pass, so the block takes one byte every cycle as long as the
// result queue (four entries) has room for two results; an accepted byte
// passes through the input register and then the result queue before its
// results reach the output. IO controller records (kind 0) and interrupt
// override records (kind 1) are reported as they complete, local controller
// records are only counted, and the flagged last byte produces a summary
// (kind 2) after any record that ends on it. The walk of records starts at
// offset 44 and stops for good at a zero length or at a record that would
// run past the declared length; records beyond the storage limits are
// dropped without a result. After a summary the block is ready for a new
// table at offset zero. No clearing pass is needed after reset.
module madt_entry_stream_parser
  import madt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  // Input register: one byte waiting to be parsed.
  in_item_t   hold;
  logic       hold_valid;

  logic       room;
  logic       advance;
  madt_push_t push;
  out_item_t  first_item;
  out_item_t  second_item;

  // A held byte is parsed once the queue can take both of its results, and
  // the register refills in the same cycle.
  assign advance  = hold_valid && room;
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_item;
    end
  end

  madt_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (hold),
    .push        (push),
    .first_item  (first_item),
    .second_item (second_item)
  );

  madt_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .first_item  (first_item),
    .second_item (second_item),
    .room        (room),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
